>>> src/qop_pkg.sv
package qop_pkg;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_QUAD  = 2'd2,
    KIND_CLOSE = 2'd3
  } seg_kind_e;

  typedef logic signed [15:0] coord_t;

  // Segments caused by one point: point segment, closing segment, close.
  localparam int unsigned MaxSegs = 3;
  typedef logic [$clog2(MaxSegs+1)-1:0] seg_cnt_t;

  typedef struct packed {
    seg_kind_e kind;
    coord_t    first_x;
    coord_t    first_y;
    coord_t    end_x;
    coord_t    end_y;
  } seg_t;

  // Points seen in the current contour, saturating at two.
  typedef logic [1:0] seen_t;
  localparam seen_t SeenNone  = 2'd0;
  localparam seen_t SeenOne   = 2'd1;
  localparam seen_t SeenTwo   = 2'd2;

  // Midpoint with the 17-bit sum halved, truncated toward zero.
  function automatic coord_t midpoint(coord_t a, coord_t b);
    logic signed [16:0] sum;
    logic signed [16:0] adj;
    sum = {a[15], a} + {b[15], b};
    adj = sum + {16'd0, sum[16]};
    return adj[16:1];
  endfunction

  // Segment to an on-curve (real or implied) point from a predecessor.
  function automatic seg_t reach(logic pon, logic md, coord_t px, coord_t py,
                                 coord_t x, coord_t y);
    seg_t s;
    s = '0;
    s.first_x = x;
    s.first_y = y;
    if (pon) begin
      s.kind = KIND_LINE;
    end else if (!md) begin
      s.kind = KIND_MOVE;
    end else begin
      s.kind    = KIND_QUAD;
      s.first_x = px;
      s.first_y = py;
      s.end_x   = x;
      s.end_y   = y;
    end
    return s;
  endfunction

endpackage

>>> src/qop_step.sv
module qop_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  qop_pkg::coord_t                   point_x_i,
  input  qop_pkg::coord_t                   point_y_i,
  input  logic                              on_curve_i,
  input  logic                              contour_end_i,
  output qop_pkg::seg_t [qop_pkg::MaxSegs-1:0] segs_o,
  output qop_pkg::seg_cnt_t                 seg_cnt_o
);

  qop_pkg::coord_t prev_x_q, prev_y_q, start_x_q, start_y_q, second_x_q, second_y_q;
  qop_pkg::coord_t prev_x_d, prev_y_d, start_x_d, start_y_d, second_x_d, second_y_d;
  logic            prev_on_q, start_on_q, second_on_q, move_done_q;
  logic            prev_on_d, start_on_d, second_on_d, move_done_d;
  qop_pkg::seen_t  seen_q, seen_d;

  qop_pkg::seg_t   pt_seg, cl_seg, close_seg;
  logic            has_pt;
  logic            md_mid;
  qop_pkg::coord_t sec_x, sec_y;
  logic            sec_on;

  always_comb begin
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_on_d   = prev_on_q;
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    start_on_d  = start_on_q;
    second_x_d  = second_x_q;
    second_y_d  = second_y_q;
    second_on_d = second_on_q;
    move_done_d = move_done_q;
    seen_d      = seen_q;

    close_seg      = '0;
    close_seg.kind = qop_pkg::KIND_CLOSE;
    pt_seg         = '0;
    cl_seg         = '0;
    has_pt         = 1'b0;
    md_mid         = move_done_q;
    segs_o         = '0;
    seg_cnt_o      = '0;

    // Second point as it stands after this point is taken in.
    sec_x  = (seen_q == qop_pkg::SeenOne) ? point_x_i  : second_x_q;
    sec_y  = (seen_q == qop_pkg::SeenOne) ? point_y_i  : second_y_q;
    sec_on = (seen_q == qop_pkg::SeenOne) ? on_curve_i : second_on_q;

    if (seen_q == qop_pkg::SeenNone) begin
      move_done_d = 1'b0;
      // A single-point contour gives nothing.
      if (!contour_end_i) begin
        start_x_d  = point_x_i;
        start_y_d  = point_y_i;
        start_on_d = on_curve_i;
        prev_x_d   = point_x_i;
        prev_y_d   = point_y_i;
        prev_on_d  = on_curve_i;
        seen_d     = qop_pkg::SeenOne;
        if (on_curve_i) begin
          pt_seg.kind    = qop_pkg::KIND_MOVE;
          pt_seg.first_x = point_x_i;
          pt_seg.first_y = point_y_i;
          has_pt         = 1'b1;
          move_done_d    = 1'b1;
        end
      end
      segs_o[0] = pt_seg;
      seg_cnt_o = has_pt ? qop_pkg::seg_cnt_t'(1) : qop_pkg::seg_cnt_t'(0);
    end else begin
      if (!on_curve_i && !prev_on_q) begin
        pt_seg = qop_pkg::reach(1'b0, move_done_q, prev_x_q, prev_y_q,
                                qop_pkg::midpoint(point_x_i, prev_x_q),
                                qop_pkg::midpoint(point_y_i, prev_y_q));
        has_pt = 1'b1;
        md_mid = 1'b1;
      end else if (on_curve_i) begin
        pt_seg = qop_pkg::reach(prev_on_q, move_done_q, prev_x_q, prev_y_q,
                                point_x_i, point_y_i);
        has_pt = 1'b1;
        md_mid = move_done_q | ~prev_on_q;
      end
      move_done_d = md_mid;
      prev_x_d    = point_x_i;
      prev_y_d    = point_y_i;
      prev_on_d   = on_curve_i;
      if (seen_q == qop_pkg::SeenOne) begin
        second_x_d  = point_x_i;
        second_y_d  = point_y_i;
        second_on_d = on_curve_i;
        seen_d      = qop_pkg::SeenTwo;
      end

      // Close back to the contour start.
      if (!start_on_q && !on_curve_i) begin
        cl_seg = qop_pkg::reach(1'b0, md_mid, point_x_i, point_y_i,
                                qop_pkg::midpoint(start_x_q, point_x_i),
                                qop_pkg::midpoint(start_y_q, point_y_i));
      end else if (start_on_q) begin
        cl_seg = qop_pkg::reach(on_curve_i, md_mid, point_x_i, point_y_i,
                                start_x_q, start_y_q);
      end else if (!sec_on) begin
        cl_seg = qop_pkg::reach(1'b0, md_mid, start_x_q, start_y_q,
                                qop_pkg::midpoint(sec_x, start_x_q),
                                qop_pkg::midpoint(sec_y, start_y_q));
      end else begin
        cl_seg = qop_pkg::reach(1'b0, md_mid, start_x_q, start_y_q, sec_x, sec_y);
      end

      if (contour_end_i) begin
        seen_d      = qop_pkg::SeenNone;
        move_done_d = 1'b0;
        if (has_pt) begin
          segs_o    = {close_seg, cl_seg, pt_seg};
          seg_cnt_o = qop_pkg::seg_cnt_t'(3);
        end else begin
          segs_o    = {close_seg, close_seg, cl_seg};
          seg_cnt_o = qop_pkg::seg_cnt_t'(2);
        end
      end else begin
        segs_o[0] = pt_seg;
        seg_cnt_o = has_pt ? qop_pkg::seg_cnt_t'(1) : qop_pkg::seg_cnt_t'(0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_on_q   <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_on_q  <= 1'b0;
      second_x_q  <= '0;
      second_y_q  <= '0;
      second_on_q <= 1'b0;
      move_done_q <= 1'b0;
      seen_q      <= qop_pkg::SeenNone;
    end else if (accept_i) begin
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      prev_on_q   <= prev_on_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      start_on_q  <= start_on_d;
      second_x_q  <= second_x_d;
      second_y_q  <= second_y_d;
      second_on_q <= second_on_d;
      move_done_q <= move_done_d;
      seen_q      <= seen_d;
    end
  end

endmodule

>>> src/qop_outq.sv
module qop_outq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  qop_pkg::seg_t [qop_pkg::MaxSegs-1:0] segs_i,
  input  qop_pkg::seg_cnt_t                 seg_cnt_i,
  input  logic                              out_stall_i,
  output qop_pkg::seg_t                     seg_o,
  output logic                              out_valid_o,
  output logic                              last_o,
  output logic                              ready_o
);

  qop_pkg::seg_t [qop_pkg::MaxSegs-1:0] segs_q;
  qop_pkg::seg_cnt_t                    cnt_q;
  logic                                 xfer;

  assign out_valid_o = (cnt_q != '0);
  assign xfer        = out_valid_o && !out_stall_i;
  assign seg_o       = segs_q[0];
  assign last_o      = (cnt_q == qop_pkg::seg_cnt_t'(1));
  // Take a new batch when empty or when the last entry leaves this cycle.
  assign ready_o     = (cnt_q == '0) || (last_o && !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= seg_cnt_i;
    end else if (xfer) begin
      cnt_q <= cnt_q - qop_pkg::seg_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      segs_q <= segs_i;
    end else if (xfer) begin
      for (int i = 0; i < qop_pkg::MaxSegs - 1; i++) begin
        segs_q[i] <= segs_q[i+1];
      end
    end
  end

endmodule

>>> src/quadratic_outline_to_path_segments.sv
// Glyph outline points in, path segments out. One point transfers per cycle
// while the output does not stall, as long as it causes at most one segment; a
// point that ends a contour of two or more points causes two or three segments
// (its own segment if any, the segment closing back to the contour start, then
// a close), and the input stalls until all but the last of them have left.
// The stall is set by the single output port draining the three-entry result
// buffer. Results are registered and appear in the cycle after their point
// transfers in. Implied on-curve points between two control points are
// computed as the midpoint with the sum truncated toward zero. A contour of
// a single point produces nothing. last_of_run_o marks the final segment
// caused by one input point.
module quadratic_outline_to_path_segments (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // point input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     point_x_i,
  input  logic signed [15:0]     point_y_i,
  input  logic                   on_curve_i,
  input  logic                   contour_end_i,
  // segment output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             segment_kind_o,
  output logic signed [15:0]     first_x_o,
  output logic signed [15:0]     first_y_o,
  output logic signed [15:0]     end_x_o,
  output logic signed [15:0]     end_y_o,
  output logic                   last_of_run_o
);

  logic                                 accept;
  logic                                 q_ready;
  qop_pkg::seg_t [qop_pkg::MaxSegs-1:0] segs;
  qop_pkg::seg_cnt_t                    seg_cnt;
  qop_pkg::seg_t                        seg_out;

  // Hold the input while the buffer has more than one segment to send, or its last one is stalled.
  assign in_stall_o = !q_ready;
  assign accept     = in_valid_i && q_ready;

  // Contour tracking and segment generation for the point at the port.
  qop_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .on_curve_i    (on_curve_i),
    .contour_end_i (contour_end_i),
    .segs_o        (segs),
    .seg_cnt_o     (seg_cnt)
  );

  // Result buffer: load a batch on each transfer in, advance on transfer out.
  qop_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .segs_i      (segs),
    .seg_cnt_i   (seg_cnt),
    .out_stall_i (out_stall_i),
    .seg_o       (seg_out),
    .out_valid_o (out_valid_o),
    .last_o      (last_of_run_o),
    .ready_o     (q_ready)
  );

  assign segment_kind_o = seg_out.kind;
  assign first_x_o      = seg_out.first_x;
  assign first_y_o      = seg_out.first_y;
  assign end_x_o        = seg_out.end_x;
  assign end_y_o        = seg_out.end_y;

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qop_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest legal stretch is a sender gap plus three results each held by a
  // full receiver stall burst.
  localparam int unsigned HangLimit   = 2000;
  // Slack after the last owed segment, to catch late extras.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;

  // One expected path segment, with the end-of-run mark of its point.
  typedef struct {
    seg_kind_e kind;
    coord_t    first_x;
    coord_t    first_y;
    coord_t    end_x;
    coord_t    end_y;
    logic      last;
  } path_seg_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  logic   in_stall_o;
  coord_t point_x_i     = '0;
  coord_t point_y_i     = '0;
  logic   on_curve_i    = 1'b0;
  logic   contour_end_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i   = 1'b0;
  logic [1:0] segment_kind_o;
  coord_t first_x_o;
  coord_t first_y_o;
  coord_t end_x_o;
  coord_t end_y_o;
  logic   last_of_run_o;

  // Random idling on both channels; cleared for the final stretch of the run.
  bit          idle_en     = 1'b0;
  int unsigned n_errors    = 0;
  int unsigned quiet_ticks = 0;

  // Segments still owed by the block, oldest first.
  path_seg_t pending_segs[$];
  // Segments caused by the point being predicted.
  path_seg_t point_segs[$];

  // Contour state of the predictor.
  coord_t ctr_prev_x, ctr_prev_y, ctr_start_x, ctr_start_y, ctr_second_x, ctr_second_y;
  logic   ctr_prev_on, ctr_start_on, ctr_second_on, ctr_moved;
  seen_t  ctr_seen;

  quadratic_outline_to_path_segments u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .on_curve_i    (on_curve_i),
    .contour_end_i (contour_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .segment_kind_o(segment_kind_o),
    .first_x_o     (first_x_o),
    .first_y_o     (first_y_o),
    .end_x_o       (end_x_o),
    .end_y_o       (end_y_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Implied on-curve coordinate: widen, add, halve toward zero.
  function automatic coord_t implied_coord(coord_t a, coord_t b);
    int sum;
    sum = int'(a) + int'(b);
    return coord_t'(sum / 2);
  endfunction

  function automatic void emit_seg(seg_kind_e kind, coord_t fx, coord_t fy,
                                   coord_t ex, coord_t ey);
    path_seg_t s;
    s.kind    = kind;
    s.first_x = fx;
    s.first_y = fy;
    s.end_x   = ex;
    s.end_y   = ey;
    s.last    = 1'b0;
    point_segs.push_back(s);
  endfunction

  // Segment reaching on-curve point (x,y) from predecessor (px,py). An on-curve
  // predecessor gives a line; a control predecessor gives the contour's move
  // if none has gone out yet, otherwise a quadratic through it.
  function automatic void segment_to(coord_t px, coord_t py, logic pon,
                                     coord_t x, coord_t y);
    if (pon) begin
      emit_seg(KIND_LINE, x, y, '0, '0);
    end else if (!ctr_moved) begin
      emit_seg(KIND_MOVE, x, y, '0, '0);
      ctr_moved = 1'b1;
    end else begin
      emit_seg(KIND_QUAD, px, py, x, y);
    end
  endfunction

  function automatic void reset_contour();
    ctr_prev_x   = '0;
    ctr_prev_y   = '0;
    ctr_start_x  = '0;
    ctr_start_y  = '0;
    ctr_second_x = '0;
    ctr_second_y = '0;
    ctr_prev_on  = 1'b0;
    ctr_start_on = 1'b0;
    ctr_second_on = 1'b0;
    ctr_moved    = 1'b0;
    ctr_seen     = SeenNone;
  endfunction

  // Work out the segments one accepted point causes and queue them.
  function automatic void predict_point(coord_t x, coord_t y, logic on, logic last);
    point_segs.delete();
    if (ctr_seen == SeenNone) begin
      ctr_moved = 1'b0;
      // A point that opens and ends its contour gives nothing.
      if (!last) begin
        ctr_start_x  = x;
        ctr_start_y  = y;
        ctr_start_on = on;
        ctr_prev_x   = x;
        ctr_prev_y   = y;
        ctr_prev_on  = on;
        ctr_seen     = SeenOne;
        if (on) begin
          emit_seg(KIND_MOVE, x, y, '0, '0);
          ctr_moved = 1'b1;
        end
      end
    end else begin
      if (!on && !ctr_prev_on) begin
        segment_to(ctr_prev_x, ctr_prev_y, 1'b0,
                   implied_coord(x, ctr_prev_x), implied_coord(y, ctr_prev_y));
      end else if (on) begin
        segment_to(ctr_prev_x, ctr_prev_y, ctr_prev_on, x, y);
      end
      ctr_prev_x  = x;
      ctr_prev_y  = y;
      ctr_prev_on = on;
      if (ctr_seen == SeenOne) begin
        ctr_second_x  = x;
        ctr_second_y  = y;
        ctr_second_on = on;
        ctr_seen      = SeenTwo;
      end
      if (last) begin
        // Close back to the start; which segment depends on the flags of the
        // start, the second and the last point.
        if (!ctr_start_on && !ctr_prev_on) begin
          segment_to(ctr_prev_x, ctr_prev_y, 1'b0,
                     implied_coord(ctr_start_x, ctr_prev_x),
                     implied_coord(ctr_start_y, ctr_prev_y));
        end else if (ctr_start_on) begin
          segment_to(ctr_prev_x, ctr_prev_y, ctr_prev_on, ctr_start_x, ctr_start_y);
        end else if (!ctr_second_on) begin
          segment_to(ctr_start_x, ctr_start_y, 1'b0,
                     implied_coord(ctr_second_x, ctr_start_x),
                     implied_coord(ctr_second_y, ctr_start_y));
        end else begin
          segment_to(ctr_start_x, ctr_start_y, 1'b0, ctr_second_x, ctr_second_y);
        end
        emit_seg(KIND_CLOSE, '0, '0, '0, '0);
        ctr_seen  = SeenNone;
        ctr_moved = 1'b0;
      end
    end
    if (point_segs.size() > 0) point_segs[point_segs.size()-1].last = 1'b1;
    foreach (point_segs[i]) pending_segs.push_back(point_segs[i]);
  endfunction

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("%t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input transfer, check every output transfer.
  // Prediction runs first so a same-cycle result would still find its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    path_seg_t e;
    bit        moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_point(point_x_i, point_y_i, on_curve_i, contour_end_i);
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_segs.size() == 0) begin
        flag_error($sformatf("unexpected segment kind=%0d first=(%0d,%0d) end=(%0d,%0d)",
                             segment_kind_o, first_x_o, first_y_o, end_x_o, end_y_o));
      end else begin
        e = pending_segs.pop_front();
        if (segment_kind_o !== e.kind || first_x_o !== e.first_x ||
            first_y_o !== e.first_y || end_x_o !== e.end_x ||
            end_y_o !== e.end_y || last_of_run_o !== e.last) begin
          flag_error($sformatf({"segment mismatch: expected kind=%0d first=(%0d,%0d) ",
                                "end=(%0d,%0d) last=%0b, got kind=%0d first=(%0d,%0d) ",
                                "end=(%0d,%0d) last=%0b"},
                               e.kind, e.first_x, e.first_y, e.end_x, e.end_y, e.last,
                               segment_kind_o, first_x_o, first_y_o, end_x_o, end_y_o,
                               last_of_run_o));
        end
      end
    end
    quiet_ticks = moved ? 0 : quiet_ticks + 1;
  end

  // Hang detection: no transfer for too long ends the run.
  initial begin
    while (quiet_ticks < HangLimit) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stall in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one point and hold it until it transfers. An optional idle burst
  // goes in front; valid stays high between back-to-back points.
  task automatic send_point(coord_t x, coord_t y, logic on, logic last);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    on_curve_i    <= on;
    contour_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mix of full-range, near-origin and extreme coordinates.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 16) - 8);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Send one well-formed contour of len points with random flags and content.
  task automatic send_contour(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), i == len - 1);
    end
  endtask

  // All on-curve contour at the coordinate extremes: move, lines, close.
  task automatic test_extreme_polygon();
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_point(16'sh0000, 16'sh7fff, 1'b1, 1'b1);
  endtask

  // Lone points give nothing and the following contour starts cleanly.
  task automatic test_single_point_contours();
    send_point(16'sd5, 16'sd5, 1'b1, 1'b1);
    send_point(16'sd7, -16'sd7, 1'b0, 1'b1);
    send_point(16'sd1, 16'sd2, 1'b1, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b0, 1'b1);
  endtask

  // Contours that open on a control point, one for each way of closing.
  task automatic test_control_point_starts();
    // control start, control end: closing point is implied
    send_point(16'sd10, 16'sd20, 1'b0, 1'b0);
    send_point(16'sd30, 16'sd41, 1'b0, 1'b0);
    send_point(-16'sd5, 16'sd7, 1'b0, 1'b1);
    // control start, control second, on-curve end
    send_point(-16'sd100, 16'sd9, 1'b0, 1'b0);
    send_point(16'sd33, -16'sd3, 1'b0, 1'b0);
    send_point(16'sd50, 16'sd50, 1'b1, 1'b1);
    // control start, on-curve second, on-curve end
    send_point(16'sd1, 16'sd1, 1'b0, 1'b0);
    send_point(16'sd2, 16'sd8, 1'b1, 1'b0);
    send_point(-16'sd4, 16'sd6, 1'b1, 1'b1);
    // two control points only
    send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
  endtask

  // Runs of control points: implied midpoints with odd, negative and
  // overflowing sums, all truncated toward zero.
  task automatic test_midpoint_truncation();
    send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_point(-16'sd1, 16'sh8000, 1'b0, 1'b0);
    send_point(16'sd0, 16'sh8000, 1'b0, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_point(16'sh8000, 16'sd3, 1'b0, 1'b0);
    send_point(16'sh7fff, 16'sd0, 1'b1, 1'b1);
  endtask

  // Random outline: mostly well-formed contours, some lone points, and a
  // little noise with the end mark set at random.
  task automatic test_random_outline(int unsigned n_points);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_points) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        len = $urandom_range(2, 8);
        send_contour(len);
        sent += len;
      end else if (pick < 19) begin
        send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    reset_contour();
    // Hold reset, then release it at a clock edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_en = 1'b1;
    test_extreme_polygon();
    test_single_point_contours();
    test_control_point_starts();
    test_midpoint_truncation();
    test_random_outline(240);
    // Final stretch at full rate on both sides.
    idle_en = 1'b0;
    test_random_outline(60);
    in_valid_i <= 1'b0;

    // Drain every owed segment, then allow for late extras.
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0 && pending_segs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
